// ===== rtl/hptc_pkg.sv =====
`default_nettype none
package hptc_pkg;

   // Pipeline depth of each section.
   localparam int TEMP_LAT   = 4;
   localparam int PPRE_LAT   = 6;
   localparam int DIV_STAGES = 64;
   localparam int PPOST_LAT  = 6;
   localparam int HUM_LAT    = 9;
   localparam int PRESS_LAT  = PPRE_LAT + DIV_STAGES + PPOST_LAT;
   localparam int HUM_DLY    = PRESS_LAT - HUM_LAT;
   localparam int TOTAL_LAT  = TEMP_LAT + PRESS_LAT;

   typedef enum logic [2:0] {
      CSR_TEMP_CALIB = 3'd0,
      CSR_PRESS_A    = 3'd1,
      CSR_PRESS_B    = 3'd2,
      CSR_PRESS_C    = 3'd3,
      CSR_HUM_CALIB  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic neg;
      logic dz;
   } div_flags_type;

   localparam logic signed [31:0] TEMP_ROUND      = 32'sd128;
   localparam logic signed [31:0] TEMP_MIN        = -32'sd65536;
   localparam logic signed [31:0] TEMP_MAX        = 32'sd65535;
   localparam logic signed [32:0] TF_PRESS_OFFSET = 33'sd128000;
   localparam logic [20:0]        PRESS_BASE      = 21'd1048576;
   localparam logic [63:0]        PRESS_SCALE     = 64'd3125;
   localparam logic [63:0]        PRESS_BIAS      = 64'h0000_8000_0000_0000;
   localparam logic signed [63:0] PRESS_MAX       = 64'sh0000_0000_FFFF_FFFF;
   localparam logic signed [31:0] TF_HUM_OFFSET   = 32'sd76800;
   localparam logic signed [31:0] HUM_LIMIT       = 32'sd419430400;
   localparam logic signed [31:0] HUM_ROUND       = 32'sd16384;
   localparam logic signed [31:0] HUM_BASE        = 32'sd2097152;
   localparam logic signed [31:0] HUM_HALF        = 32'sd32768;
   localparam logic signed [31:0] HUM_ROUND2      = 32'sd8192;
   localparam logic [16:0]        HUM_MAX         = 17'd102400;

endpackage
`default_nettype wire

// ===== rtl/hptc_temp.sv =====
`default_nettype none
module hptc_temp import hptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [19:0]        raw_p,
   input  logic [19:0]        raw_t,
   input  logic [15:0]        raw_h,
   input  logic [47:0]        temp_calib,
   output logic               out_valid,
   output logic signed [31:0] tf,
   output logic signed [16:0] temp_centi,
   output logic [19:0]        raw_p_out,
   output logic [15:0]        raw_h_out
);

   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic signed [17:0] a;
   logic signed [16:0] b;
   logic signed [33:0] at2_full, bb_full;
   logic signed [31:0] v1_in, bb12, tf_in, m_sh, tc5, tc;
   logic signed [47:0] m_full;
   logic signed [16:0] tcent_in;

   logic [3:0]         vld_ff;
   logic [31:0]        at2_ff, bb_ff, m_ff;
   logic signed [31:0] v1_ff, tf_ff, tf_out_ff;
   logic signed [16:0] tcent_ff;
   logic [19:0]        rawp_ff [0:3];
   logic [15:0]        rawh_ff [0:3];

   always_comb begin
      t1       = temp_calib[15:0];
      t2       = $signed(temp_calib[31:16]);
      t3       = $signed(temp_calib[47:32]);
      a        = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
      b        = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});
      at2_full = a * t2;
      bb_full  = b * b;
      v1_in    = $signed(at2_ff) >>> 11;
      bb12     = $signed(bb_ff) >>> 12;
      m_full   = bb12 * t3;
      m_sh     = $signed(m_ff) >>> 14;
      tf_in    = v1_ff + m_sh;
      tc5      = tf_ff + (tf_ff <<< 2) + TEMP_ROUND;
      tc       = tc5 >>> 8;
      if (tc < TEMP_MIN) begin
         tcent_in = TEMP_MIN[16:0];
      end else if (tc > TEMP_MAX) begin
         tcent_in = TEMP_MAX[16:0];
      end else begin
         tcent_in = tc[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      at2_ff     <= at2_full[31:0];
      bb_ff      <= bb_full[31:0];
      v1_ff      <= v1_in;
      m_ff       <= m_full[31:0];
      tf_ff      <= tf_in;
      tf_out_ff  <= tf_ff;
      tcent_ff   <= tcent_in;
      rawp_ff[0] <= raw_p;
      rawh_ff[0] <= raw_h;
      for (int i = 1; i < 4; i++) begin
         rawp_ff[i] <= rawp_ff[i-1];
         rawh_ff[i] <= rawh_ff[i-1];
      end
   end

   assign out_valid  = vld_ff[3];
   assign tf         = tf_out_ff;
   assign temp_centi = tcent_ff;
   assign raw_p_out  = rawp_ff[3];
   assign raw_h_out  = rawh_ff[3];

endmodule
`default_nettype wire

// ===== rtl/hptc_ppre.sv =====
`default_nettype none
module hptc_ppre import hptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] tf,
   input  logic [19:0]        raw_p,
   input  logic [63:0]        press_calib_a,
   input  logic [63:0]        press_calib_b,
   output logic               out_valid,
   output logic [63:0]        an,
   output logic [30:0]        ad,
   output div_flags_type      flags
);

   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6;
   logic signed [32:0] w1;
   logic signed [65:0] w1sq_full;
   logic signed [48:0] w1p5_full, w1p2_full;
   logic signed [63:0] w2a_in, w1a_in, w1a_sh, w1b_in;
   logic [63:0]        w2_in, prod_in, n0_in, n_in;
   logic [20:0]        pp;

   logic [5:0]         vld_ff;
   logic [63:0]        w1sq_ff, w2a_ff, w1a_ff, w2_ff, prod_ff, n0_ff, n_ff;
   logic signed [48:0] w1p5_ff, w1p2_ff, w1p5_d_ff, w1p2_d_ff;
   logic signed [63:0] w1b_ff;
   logic signed [30:0] d_ff;
   logic [19:0]        rawp_ff [0:2];
   logic [63:0]        an_ff;
   logic [30:0]        ad_ff;
   div_flags_type      flags_ff;

   always_comb begin
      p1        = press_calib_a[15:0];
      p2        = $signed(press_calib_a[31:16]);
      p3        = $signed(press_calib_a[47:32]);
      p4        = $signed(press_calib_a[63:48]);
      p5        = $signed(press_calib_b[15:0]);
      p6        = $signed(press_calib_b[31:16]);
      w1        = $signed({tf[31], tf}) - TF_PRESS_OFFSET;
      w1sq_full = w1 * w1;
      w1p5_full = w1 * p5;
      w1p2_full = w1 * p2;
      w2a_in    = $signed(w1sq_ff) * p6;
      w1a_in    = $signed(w1sq_ff) * p3;
      w2_in     = w2a_ff + ({{15{w1p5_d_ff[48]}}, w1p5_d_ff} << 17)
                  + ({{48{p4[15]}}, p4} << 35);
      w1a_sh    = $signed(w1a_ff) >>> 8;
      w1b_in    = w1a_sh + $signed({{15{w1p2_d_ff[48]}}, w1p2_d_ff} << 12);
      prod_in   = (PRESS_BIAS + w1b_ff) * {48'b0, p1};
      pp        = PRESS_BASE - {1'b0, rawp_ff[2]};
      n0_in     = ({43'b0, pp} << 31) - w2_ff;
      n_in      = n0_ff * PRESS_SCALE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      w1sq_ff    <= w1sq_full[63:0];
      w1p5_ff    <= w1p5_full;
      w1p2_ff    <= w1p2_full;
      w1p5_d_ff  <= w1p5_ff;
      w1p2_d_ff  <= w1p2_ff;
      rawp_ff[0] <= raw_p;
      rawp_ff[1] <= rawp_ff[0];
      rawp_ff[2] <= rawp_ff[1];
      w2a_ff     <= w2a_in;
      w1a_ff     <= w1a_in;
      w2_ff      <= w2_in;
      w1b_ff     <= w1b_in;
      prod_ff    <= prod_in;
      n0_ff      <= n0_in;
      d_ff       <= $signed(prod_ff[63:33]);
      n_ff       <= n_in;
      // Split into magnitudes, a result sign and a zero-divisor flag for the unsigned divider.
      an_ff        <= n_ff[63] ? (64'd0 - n_ff) : n_ff;
      ad_ff        <= d_ff[30] ? (31'd0 - d_ff) : d_ff;
      flags_ff.neg <= n_ff[63] ^ d_ff[30];
      flags_ff.dz  <= (d_ff == '0);
   end

   assign out_valid = vld_ff[5];
   assign an        = an_ff;
   assign ad        = ad_ff;
   assign flags     = flags_ff;

endmodule
`default_nettype wire

// ===== rtl/hptc_div.sv =====
`default_nettype none
module hptc_div import hptc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [63:0]   an,
   input  logic [30:0]   ad,
   input  div_flags_type flags_in,
   output logic          out_valid,
   output logic [63:0]   quo,
   output div_flags_type flags_out
);

   typedef struct packed {
      logic [30:0] rem;
      logic [63:0] nq;
   } div_state_type;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   function automatic div_state_type div_step(input div_state_type s, input logic [30:0] d);
      logic [31:0]   r2;
      logic          ge;
      div_state_type o;
      r2    = {s.rem, s.nq[63]};
      ge    = (r2 >= {1'b0, d});
      o.rem = ge ? 31'(r2 - {1'b0, d}) : r2[30:0];
      o.nq  = {s.nq[62:0], ge};
      return o;
   endfunction

   div_state_type st_in    [0:DIV_STAGES-1];
   div_state_type st_ff    [0:DIV_STAGES-1];
   logic [30:0]   ad_ff    [0:DIV_STAGES-1];
   div_flags_type flags_ff [0:DIV_STAGES-1];
   logic [DIV_STAGES-1:0] vld_ff;

   always_comb begin
      st_in[0] = div_step('{rem: '0, nq: an}, ad);
      for (int k = 1; k < DIV_STAGES; k++) begin
         st_in[k] = div_step(st_ff[k-1], ad_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      st_ff[0]    <= st_in[0];
      ad_ff[0]    <= ad;
      flags_ff[0] <= flags_in;
      for (int k = 1; k < DIV_STAGES; k++) begin
         st_ff[k]    <= st_in[k];
         ad_ff[k]    <= ad_ff[k-1];
         flags_ff[k] <= flags_ff[k-1];
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quo       = st_ff[DIV_STAGES-1].nq;
   assign flags_out = flags_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/hptc_ppost.sv =====
`default_nettype none
module hptc_ppost import hptc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [63:0]   quo,
   input  div_flags_type flags,
   input  logic [63:0]   press_calib_b,
   input  logic [15:0]   press_calib_c,
   output logic          out_valid,
   output logic [31:0]   pressure,
   output logic          pressure_valid
);

   logic signed [15:0] p7, p8, p9;
   logic signed [50:0] ps;
   logic [31:0]        lo, hi32, hilo_in;
   logic [63:0]        lolo_in, pss_in;
   logic signed [63:0] e2p_in, e1p_in, e2_in, e1, sum_in, sh, r, p7x;
   logic [31:0]        press_in;

   logic [5:0]         vld_ff;
   logic [4:0]         dz_ff;
   logic signed [63:0] p_ff [0:3];
   logic [63:0]        lolo_ff, pss_ff;
   logic [31:0]        hilo_ff;
   logic signed [63:0] e2p_ff, e1p_ff, e2_ff, sum_ff;
   logic [31:0]        press_ff;
   logic               pv_ff;

   always_comb begin
      p7      = $signed(press_calib_b[47:32]);
      p8      = $signed(press_calib_b[63:48]);
      p9      = $signed(press_calib_c);
      // Square of p >>> 13 modulo 2^64 from two 32-bit partial products.
      ps      = p_ff[0][63:13];
      lo      = ps[31:0];
      hi32    = {{13{ps[50]}}, ps[50:32]};
      lolo_in = {32'b0, lo} * {32'b0, lo};
      hilo_in = hi32 * lo;
      e2p_in  = p_ff[1] * p8;
      pss_in  = lolo_ff + {hilo_ff[30:0], 33'b0};
      e1p_in  = $signed(pss_ff) * p9;
      e2_in   = e2p_ff >>> 19;
      e1      = e1p_ff >>> 25;
      sum_in  = p_ff[3] + e1 + e2_ff;
      sh      = sum_ff >>> 8;
      p7x     = $signed({{44{p7[15]}}, p7, 4'b0});
      r       = sh + p7x;
      if (dz_ff[4] || r < 64'sd0) begin
         press_in = '0;
      end else if (r > PRESS_MAX) begin
         press_in = PRESS_MAX[31:0];
      end else begin
         press_in = r[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      p_ff[0]  <= flags.neg ? $signed(64'd0 - quo) : $signed(quo);
      dz_ff    <= {dz_ff[3:0], flags.dz};
      for (int i = 1; i < 4; i++) begin
         p_ff[i] <= p_ff[i-1];
      end
      lolo_ff  <= lolo_in;
      hilo_ff  <= hilo_in;
      e2p_ff   <= e2p_in;
      pss_ff   <= pss_in;
      e1p_ff   <= e1p_in;
      e2_ff    <= e2_in;
      sum_ff   <= sum_in;
      press_ff <= press_in;
      pv_ff    <= !dz_ff[4];
   end

   assign out_valid      = vld_ff[5];
   assign pressure       = press_ff;
   assign pressure_valid = pv_ff;

endmodule
`default_nettype wire

// ===== rtl/hptc_hum.sv =====
`default_nettype none
module hptc_hum import hptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] tf,
   input  logic [15:0]        raw_h,
   input  logic [63:0]        hum_calib,
   output logic               out_valid,
   output logic [16:0]        humidity
);

   logic [7:0]         h1, h3;
   logic signed [15:0] h2;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;
   logic signed [31:0] x, xh6p_in, xh3p_in, h5x_in, f1_sum, f1_in, xh6_in, xh3_in;
   logic signed [31:0] f2a_in, f2b, f2c_in, f2_in, xx_in, s15, sq_in, sq7, t8_in;
   logic signed [31:0] hx;
   logic [16:0]        hum_in;

   logic [8:0]         vld_ff;
   logic [15:0]        rawh_ff;
   logic signed [31:0] xh6p_ff, xh3p_ff, h5x_ff, xh6_ff, xh3_ff;
   logic signed [31:0] f1_ff [0:3];
   logic signed [31:0] f2a_ff, f2c_ff, f2_ff, sq_ff, t8_ff;
   logic signed [31:0] xx_ff [0:2];
   logic [16:0]        hum_ff;

   always_comb begin
      h1      = hum_calib[7:0];
      h2      = $signed(hum_calib[23:8]);
      h3      = hum_calib[31:24];
      h4      = $signed(hum_calib[43:32]);
      h5      = $signed(hum_calib[55:44]);
      h6      = $signed(hum_calib[63:56]);
      x       = tf - TF_HUM_OFFSET;
      xh6p_in = x * h6;
      xh3p_in = x * $signed({1'b0, h3});
      h5x_in  = h5 * x;
      f1_sum  = $signed({2'b0, rawh_ff, 14'b0}) - $signed({h4, 20'b0}) - h5x_ff + HUM_ROUND;
      f1_in   = f1_sum >>> 15;
      xh6_in  = xh6p_ff >>> 10;
      xh3_in  = (xh3p_ff >>> 11) + HUM_HALF;
      f2a_in  = xh6_ff * xh3_ff;
      f2b     = (f2a_ff >>> 10) + HUM_BASE;
      f2c_in  = f2b * h2;
      f2_in   = (f2c_ff + HUM_ROUND2) >>> 14;
      xx_in   = f1_ff[3] * f2_ff;
      s15     = xx_ff[0] >>> 15;
      sq_in   = s15 * s15;
      sq7     = sq_ff >>> 7;
      t8_in   = sq7 * $signed({24'b0, h1});
      hx      = xx_ff[2] - (t8_ff >>> 4);
      // Clamp to 0..100 percent before dropping the low twelve bits.
      if (hx < 32'sd0) begin
         hum_in = '0;
      end else if (hx > HUM_LIMIT) begin
         hum_in = HUM_MAX;
      end else begin
         hum_in = hx[28:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[7:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rawh_ff  <= raw_h;
      xh6p_ff  <= xh6p_in;
      xh3p_ff  <= xh3p_in;
      h5x_ff   <= h5x_in;
      f1_ff[0] <= f1_in;
      f1_ff[1] <= f1_ff[0];
      f1_ff[2] <= f1_ff[1];
      f1_ff[3] <= f1_ff[2];
      xh6_ff   <= xh6_in;
      xh3_ff   <= xh3_in;
      f2a_ff   <= f2a_in;
      f2c_ff   <= f2c_in;
      f2_ff    <= f2_in;
      xx_ff[0] <= xx_in;
      xx_ff[1] <= xx_ff[0];
      xx_ff[2] <= xx_ff[1];
      sq_ff    <= sq_in;
      t8_ff    <= t8_in;
      hum_ff   <= hum_in;
   end

   assign out_valid = vld_ff[8];
   assign humidity  = hum_ff;

endmodule
`default_nettype wire

// ===== rtl/humidity_pressure_temp_compensation.sv =====
`default_nettype none
// Integer compensation of one raw pressure / temperature / humidity triple.
//
// Use: raise start with the three raw readings; the item is taken at every
// clock edge where start is high and busy is low. busy is low at all times
// outside reset, so a new item may enter on every cycle.
// Each result appears on the rsp_ ports for one cycle with rsp_valid high,
// once its item has passed through the pressure path, in item order. The receiver
// cannot hold results off, and none is needed: the datapath never stalls.
// Results are aligned to the pressure path: 4 temperature stages, 6 stages of
// pressure set-up, a 64-stage one-bit-per-stage divider and 6 stages of
// pressure correction. Humidity and temperature results wait in delay lines.
// Throughput: one item per cycle.
// Calibration words are written through csr_we / csr_index / csr_wdata and
// must only change while no item is in flight.
// Synchronous reset clears the calibration registers and drops every item
// in flight; no result is given for those.
module humidity_pressure_temp_compensation import hptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [19:0]        req_raw_pressure,
   input  logic [19:0]        req_raw_temperature,
   input  logic [15:0]        req_raw_humidity,
   output logic               rsp_valid,
   output logic signed [16:0] rsp_temperature_centi,
   output logic [31:0]        rsp_pressure_q24_8,
   output logic               rsp_pressure_valid,
   output logic [16:0]        rsp_humidity_q22_10,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   // Calibration registers
   logic [47:0] temp_calib_ff;
   logic [63:0] press_a_ff, press_b_ff, hum_calib_ff;
   logic [15:0] press_c_ff;

   logic               accept;
   logic               t_valid;
   logic signed [31:0] tf;
   logic signed [16:0] temp_centi;
   logic [19:0]        raw_p_t;
   logic [15:0]        raw_h_t;
   logic               pre_valid;
   logic [63:0]        an;
   logic [30:0]        ad;
   div_flags_type      pre_flags, div_flags;
   logic               div_valid;
   logic [63:0]        quo;
   logic               hum_valid;
   logic [16:0]        humidity;

   // Align temperature and humidity with the longer pressure path
   logic signed [16:0] tcent_dly_ff [0:PRESS_LAT-1];
   logic [16:0]        hum_dly_ff   [0:HUM_DLY-1];

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         press_c_ff    <= '0;
         hum_calib_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP_CALIB: temp_calib_ff <= csr_wdata[47:0];
            CSR_PRESS_A:    press_a_ff    <= csr_wdata;
            CSR_PRESS_B:    press_b_ff    <= csr_wdata;
            CSR_PRESS_C:    press_c_ff    <= csr_wdata[15:0];
            CSR_HUM_CALIB:  hum_calib_ff  <= csr_wdata;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Fine temperature and the temperature result
   hptc_temp u_temp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .raw_p      (req_raw_pressure),
      .raw_t      (req_raw_temperature),
      .raw_h      (req_raw_humidity),
      .temp_calib (temp_calib_ff),
      .out_valid  (t_valid),
      .tf         (tf),
      .temp_centi (temp_centi),
      .raw_p_out  (raw_p_t),
      .raw_h_out  (raw_h_t)
   );

   // Pressure dividend and divisor
   hptc_ppre u_ppre (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (t_valid),
      .tf            (tf),
      .raw_p         (raw_p_t),
      .press_calib_a (press_a_ff),
      .press_calib_b (press_b_ff),
      .out_valid     (pre_valid),
      .an            (an),
      .ad            (ad),
      .flags         (pre_flags)
   );

   // Pipelined unsigned divide, one quotient bit per stage
   hptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .an        (an),
      .ad        (ad),
      .flags_in  (pre_flags),
      .out_valid (div_valid),
      .quo       (quo),
      .flags_out (div_flags)
   );

   // Second-order pressure correction and saturation
   hptc_ppost u_ppost (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (div_valid),
      .quo            (quo),
      .flags          (div_flags),
      .press_calib_b  (press_b_ff),
      .press_calib_c  (press_c_ff),
      .out_valid      (rsp_valid),
      .pressure       (rsp_pressure_q24_8),
      .pressure_valid (rsp_pressure_valid)
   );

   // Humidity, reusing the fine temperature
   hptc_hum u_hum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t_valid),
      .tf        (tf),
      .raw_h     (raw_h_t),
      .hum_calib (hum_calib_ff),
      .out_valid (hum_valid),
      .humidity  (humidity)
   );

   // Advance the delay lines every cycle; valid travels in the pressure path
   always_ff @(posedge clock) begin
      tcent_dly_ff[0] <= temp_centi;
      for (int i = 1; i < PRESS_LAT; i++) begin
         tcent_dly_ff[i] <= tcent_dly_ff[i-1];
      end
      hum_dly_ff[0] <= humidity;
      for (int i = 1; i < HUM_DLY; i++) begin
         hum_dly_ff[i] <= hum_dly_ff[i-1];
      end
   end

   assign rsp_temperature_centi = tcent_dly_ff[PRESS_LAT-1];
   assign rsp_humidity_q22_10   = hum_dly_ff[HUM_DLY-1];

   // A result only ever comes from an item taken a fixed latency earlier
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, TOTAL_LAT))
      else $error("result without a matching item");

   // The humidity side stays in step with the temperature side
   a_hum_aligned: assert property (@(posedge clock) disable iff (reset)
      t_valid |-> ##HUM_LAT hum_valid)
      else $error("humidity path out of step");

   a_press_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pressure_valid) |-> (rsp_pressure_q24_8 == '0))
      else $error("invalid pressure not zero");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_humidity_q22_10 <= HUM_MAX))
      else $error("humidity above full scale");

endmodule
`default_nettype wire

// ===== dv/hptc_checker.sv =====
`timescale 1ns / 1ps
module hptc_checker import hptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [19:0]        req_raw_pressure,
   input  logic [19:0]        req_raw_temperature,
   input  logic [15:0]        req_raw_humidity,
   input  logic               rsp_valid,
   input  logic signed [16:0] rsp_temperature_centi,
   input  logic [31:0]        rsp_pressure_q24_8,
   input  logic               rsp_pressure_valid,
   input  logic [16:0]        rsp_humidity_q22_10,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   output int                 errors,
   output int                 pending,
   output int                 readings,
   output int                 no_divisor
);

   typedef struct {
      logic signed [16:0] temp;
      logic [31:0]        press;
      logic               press_ok;
      logic [16:0]        hum;
   } reading_type;

   logic [47:0] t_cal;
   logic [63:0] p_cal_a, p_cal_b, h_cal;
   logic [15:0] p_cal_c;
   reading_type expected_q[$];

   assign pending = expected_q.size();

   // signed 64-bit quotient, truncating; the most negative value over -1 wraps
   function automatic logic signed [63:0] quotient(logic signed [63:0] n, logic signed [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q  = an / ad;
      return (n[63] ^ d[63]) ? -q : q;
   endfunction

   function automatic reading_type compensate(logic [19:0] raw_p, logic [19:0] raw_t,
                                              logic [15:0] raw_h);
      reading_type r;
      logic signed [31:0] adc_t, adc_h, t1, t2, t3, a, b, v1, v2, tf, tc;
      logic signed [31:0] h1, h2, h3, h4, h5, h6, x, f1, f2, xs;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, ps, e1, e2;
      adc_t = {12'd0, raw_t};
      adc_h = {16'd0, raw_h};
      t1 = {16'd0, t_cal[15:0]};
      t2 = $signed(t_cal[31:16]);
      t3 = $signed(t_cal[47:32]);
      a  = (adc_t >>> 3) - (t1 <<< 1);
      v1 = (a * t2) >>> 11;
      b  = (adc_t >>> 4) - t1;
      v2 = (((b * b) >>> 12) * t3) >>> 14;
      tf = v1 + v2;
      tc = (tf * 32'sd5 + 32'sd128) >>> 8;
      if (tc < -32'sd65536) tc = -32'sd65536;
      if (tc > 32'sd65535) tc = 32'sd65535;
      r.temp = tc[16:0];

      p1 = {48'd0, p_cal_a[15:0]};
      p2 = $signed(p_cal_a[31:16]);
      p3 = $signed(p_cal_a[47:32]);
      p4 = $signed(p_cal_a[63:48]);
      p5 = $signed(p_cal_b[15:0]);
      p6 = $signed(p_cal_b[31:16]);
      p7 = $signed(p_cal_b[47:32]);
      p8 = $signed(p_cal_b[63:48]);
      p9 = $signed(p_cal_c);
      w1 = tf;
      w1 = w1 - 64'sd128000;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) <<< 17);
      w2 = w2 + (p4 <<< 35);
      w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
      w1 = ((64'sh0000_8000_0000_0000 + w1) * p1) >>> 33;
      r.press = '0;
      r.press_ok = 1'b0;
      if (w1 != 0) begin
         p  = 64'sd1048576 - $signed({44'd0, raw_p});
         p  = quotient(((p <<< 31) - w2) * 64'sd3125, w1);
         ps = p >>> 13;
         e1 = (p9 * ps * ps) >>> 25;
         e2 = (p8 * p) >>> 19;
         p  = ((p + e1 + e2) >>> 8) + (p7 <<< 4);
         if (p < 0) p = 0;
         if (p > 64'sh0000_0000_FFFF_FFFF) p = 64'sh0000_0000_FFFF_FFFF;
         r.press = p[31:0];
         r.press_ok = 1'b1;
      end

      h1 = {24'd0, h_cal[7:0]};
      h2 = $signed(h_cal[23:8]);
      h3 = {24'd0, h_cal[31:24]};
      h4 = $signed(h_cal[43:32]);
      h5 = $signed(h_cal[55:44]);
      h6 = $signed(h_cal[63:56]);
      x  = tf - 32'sd76800;
      f1 = ((adc_h <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384) >>> 15;
      f2 = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768);
      f2 = (f2 >>> 10) + 32'sd2097152;
      f2 = (f2 * h2 + 32'sd8192) >>> 14;
      x  = f1 * f2;
      xs = x >>> 15;
      x  = x - ((((xs * xs) >>> 7) * h1) >>> 4);
      if (x < 0) x = 0;
      if (x > 32'sd419430400) x = 32'sd419430400;
      xs = x >>> 12;
      r.hum = xs[16:0];
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         t_cal <= '0;
         p_cal_a <= '0;
         p_cal_b <= '0;
         p_cal_c <= '0;
         h_cal <= '0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_TEMP_CALIB: t_cal <= csr_wdata[47:0];
               CSR_PRESS_A:    p_cal_a <= csr_wdata;
               CSR_PRESS_B:    p_cal_b <= csr_wdata;
               CSR_PRESS_C:    p_cal_c <= csr_wdata[15:0];
               CSR_HUM_CALIB:  h_cal <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy)
            expected_q.push_back(compensate(req_raw_pressure, req_raw_temperature,
                                            req_raw_humidity));
         if (rsp_valid) begin
            readings++;
            if (!rsp_pressure_valid) no_divisor++;
            if (expected_q.size() == 0) begin
               errors++;
               $error("unexpected result: temperature_centi %0d", rsp_temperature_centi);
            end else begin
               want = expected_q.pop_front();
               if (rsp_temperature_centi !== want.temp) begin
                  errors++;
                  $error("temperature_centi expected %0d actual %0d", want.temp,
                         rsp_temperature_centi);
               end
               if (rsp_pressure_q24_8 !== want.press) begin
                  errors++;
                  $error("pressure_q24_8 expected %0d actual %0d", want.press,
                         rsp_pressure_q24_8);
               end
               if (rsp_pressure_valid !== want.press_ok) begin
                  errors++;
                  $error("pressure_valid expected %0d actual %0d", want.press_ok,
                         rsp_pressure_valid);
               end
               if (rsp_humidity_q22_10 !== want.hum) begin
                  errors++;
                  $error("humidity_q22_10 expected %0d actual %0d", want.hum,
                         rsp_humidity_q22_10);
               end
            end
         end
      end
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import hptc_pkg::*;

   // no register lives at this index; writes to it must change nothing
   localparam logic [2:0] CSR_UNMAPPED = 3'd5;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SUB_ITEMS   = 54;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [19:0]        req_raw_pressure = '0;
   logic [19:0]        req_raw_temperature = '0;
   logic [15:0]        req_raw_humidity = '0;
   logic               rsp_valid;
   logic signed [16:0] rsp_temperature_centi;
   logic [31:0]        rsp_pressure_q24_8;
   logic               rsp_pressure_valid;
   logic [16:0]        rsp_humidity_q22_10;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   int errors, pending, readings, no_divisor;
   int items_sent = 0;
   int cycles = 0;

   // typical factory trim words, packed as the registers expect
   localparam logic [63:0] TYP_TEMP = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_PA   = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] TYP_PB   = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [63:0] TYP_PC   = 64'd6000;
   localparam logic [63:0] TYP_HUM  = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   humidity_pressure_temp_compensation dut (.*);

   hptc_checker chk (.*);

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // write one calibration register; the block must be idle
   task automatic write_csr(logic [2:0] idx, logic [63:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_calib(logic [63:0] tc, logic [63:0] pa, logic [63:0] pb,
                             logic [63:0] pc, logic [63:0] hc);
      write_csr(CSR_TEMP_CALIB, tc);
      write_csr(CSR_PRESS_A, pa);
      write_csr(CSR_PRESS_B, pb);
      write_csr(CSR_PRESS_C, pc);
      write_csr(CSR_HUM_CALIB, hc);
   endtask

   // present one item and hold it until taken; busy only moves at rising edges,
   // so its value at the falling edge is what the next rising edge sees
   task automatic send(logic [19:0] p, logic [19:0] t, logic [15:0] h);
      start <= 1'b1;
      req_raw_pressure <= p;
      req_raw_temperature <= t;
      req_raw_humidity <= h;
      do @(negedge clock); while (busy);
      @(posedge clock);
      items_sent++;
   endtask

   // drop start and hold until every expected result has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // nudge each trim word of a typical part by a small random amount
   function automatic logic [63:0] jitter(logic [63:0] v);
      logic [63:0] r;
      r = v;
      for (int i = 0; i < 4; i++)
         r[i*16 +: 16] = v[i*16 +: 16] + 16'($urandom_range(0, 511)) - 16'd256;
      return r;
   endfunction

   task automatic random_items(int n, int idle_pct);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         // mostly readings near the working range of a real part, rest anywhere
         if (r < 70)
            send(20'd415148 + 20'($urandom_range(0, 200000)) - 20'd100000,
                 20'd519888 + 20'($urandom_range(0, 100000)) - 20'd50000,
                 16'($urandom_range(20000, 40000)));
         else
            send(20'($urandom), 20'($urandom), 16'($urandom));
         // each further cycle idles with the given chance
         if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
         end
      end
   endtask

   initial begin
      int idle_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: pressure divisor is zero, pressure must read invalid
      send(20'd0, 20'd0, 16'd0);
      send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send(20'd415148, 20'd519888, 16'd30000);
      drain();

      // typical trim; high bits beyond each register and an unmapped index
      load_calib(TYP_TEMP | 64'hABCD_0000_0000_0000, TYP_PA, TYP_PB,
                 TYP_PC | 64'h1234_5678_0000_0000, TYP_HUM);
      write_csr(CSR_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
      send(20'd415148, 20'd519888, 16'd30000);
      send(20'd0, 20'd519888, 16'd30000);
      send(20'hFFFFF, 20'd519888, 16'd30000);
      send(20'd415148, 20'd0, 16'd30000);
      send(20'd415148, 20'hFFFFF, 16'd30000);
      send(20'd415148, 20'd519888, 16'd0);
      send(20'd415148, 20'd519888, 16'hFFFF);
      send(20'd0, 20'd0, 16'd0);
      send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      drain();

      // all ones, then the largest positive signed words
      load_calib('1, '1, '1, '1, '1);
      send(20'd0, 20'd0, 16'd0);
      send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send(20'd415148, 20'd519888, 16'd30000);
      drain();
      load_calib(64'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                 64'h7FFF, 64'h7F7F_F7FF_FF7F_FFFF);
      send(20'd0, 20'd0, 16'd0);
      send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send(20'd415148, 20'd519888, 16'd30000);
      drain();

      // random part: three idle profiles, four calibrations each
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 7 : (phase == 1) ? 76 : 0;
         for (int sub = 0; sub < 4; sub++) begin
            if (sub[0])
               load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          64'($urandom), {$urandom, $urandom});
            else
               load_calib(jitter(TYP_TEMP) & 64'hFFFF_FFFF_FFFF, jitter(TYP_PA),
                          jitter(TYP_PB), jitter(TYP_PC) & 64'hFFFF, jitter(TYP_HUM));
            random_items(SUB_ITEMS / 2, idle_pct);
            // in the third calibration, pause the sender until the pipeline is empty, then carry on
            if (sub == 2) drain();
            random_items(SUB_ITEMS - SUB_ITEMS / 2, idle_pct);
            drain();
         end
      end

      repeat (TOTAL_LAT + 20) @(posedge clock);
      $display("tb_top: %0d items sent, %0d results checked, %0d without pressure divisor",
               items_sent, readings, no_divisor);
      $display("tb_top: zero, all-ones, max-positive, typical and random calibrations");
      if (errors == 0 && pending == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== humidity_pressure_temp_compensation.f =====
rtl/hptc_pkg.sv
rtl/hptc_temp.sv
rtl/hptc_ppre.sv
rtl/hptc_div.sv
rtl/hptc_ppost.sv
rtl/hptc_hum.sv
rtl/humidity_pressure_temp_compensation.sv
dv/hptc_checker.sv
dv/tb_top.sv
